// ===== rtl/pdgc_pkg.sv =====
// Shared widths, register indexes and divider handshake types for the PID controller.
package pdgc_pkg;

  // Field widths fixed by the register map and the sample format
  localparam int unsigned SPEED_W  = 16;  // target and measured speed
  localparam int unsigned DIV_W    = 15;  // divisor registers
  localparam int unsigned LIMIT_W  = 15;  // integral bound
  localparam int unsigned ERR_W    = 17;  // target - measured
  localparam int unsigned INTEG_W  = 16;  // clamped integral sum
  localparam int unsigned NUM_W    = 18;  // widest dividend: error difference
  localparam int unsigned ACC_W    = 20;  // sum of three quotients
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned DEFAULT_DATA_WIDTH = 16;

  // Divider: quotient bits resolved per cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 2;
  localparam int unsigned DIV_STEPS = NUM_W / DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_TARGET_SPEED   = 3'd0;
  localparam logic [2:0] REG_P_DIVISOR      = 3'd1;
  localparam logic [2:0] REG_I_DIVISOR      = 3'd2;
  localparam logic [2:0] REG_D_DIVISOR      = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DIV_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/pid_divisor_gain_controller.sv =====
// PID controller with divisor gains, clamped integral and saturated drive output.
// Each accepted sample runs an error/integral update (PREP), then three divisions (P, I, D)
// sharing one 2-bit-per-cycle divider, then saturation (OUT) into the output register;
// a new sample is taken only once the last result is loaded (in_ready_o only in IDLE).
// Reset (rst_ni low, async): setpoint 0, divisors 1, integral limit 0,
// integral sum and previous error 0, no result pending.
module pid_divisor_gain_controller
  import pdgc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB-style configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  // sample channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SPEED_W-1:0]    measured_speed_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] drive_value_o,
  output logic                         output_saturated_o
);

  // Saturation is done in a width that holds both the accumulator and the output range
  localparam int unsigned EXT_W = ((DATA_WIDTH > ACC_W) ? DATA_WIDTH : ACC_W) + 1;
  localparam logic signed [EXT_W-1:0] SAT_HI =
      EXT_W'((65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;  // error, integral clamp, difference
  localparam logic [2:0] ST_DIV_P = 3'd2;
  localparam logic [2:0] ST_DIV_I = 3'd3;
  localparam logic [2:0] ST_DIV_D = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;  // saturate into the output register

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] target_q;
  logic [DIV_W-1:0]          p_div_q, i_div_q, d_div_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      p_div_q  <= DIV_W'(1);
      i_div_q  <= DIV_W'(1);
      d_div_q  <= DIV_W'(1);
      limit_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_SPEED:   target_q <= pwdata[SPEED_W-1:0];
        REG_P_DIVISOR:      p_div_q  <= pwdata[DIV_W-1:0];
        REG_I_DIVISOR:      i_div_q  <= pwdata[DIV_W-1:0];
        REG_D_DIVISOR:      d_div_q  <= pwdata[DIV_W-1:0];
        REG_INTEGRAL_LIMIT: limit_q  <= pwdata[LIMIT_W-1:0];
        default: ;  // addresses past the map are ignored
      endcase
    end
  end

  // Readback; setpoint sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_TARGET_SPEED:   prdata = APB_DW'(target_q);
      REG_P_DIVISOR:      prdata = APB_DW'(p_div_q);
      REG_I_DIVISOR:      prdata = APB_DW'(i_div_q);
      REG_D_DIVISOR:      prdata = APB_DW'(d_div_q);
      REG_INTEGRAL_LIMIT: prdata = APB_DW'(limit_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Controller state and datapath
  // ---------------------------------------------------------------------------
  logic [2:0]                state_q, state_d;
  logic                      start_q, start_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SPEED_W-1:0] meas_q, meas_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;   // clamped integral sum
  logic signed [ERR_W-1:0]   prev_err_q, prev_err_d;  // also this step's error
  logic signed [NUM_W-1:0]   diff_q, diff_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [DATA_WIDTH-1:0] drive_q, drive_d;
  logic                      sat_q, sat_d;

  // Step arithmetic, used in the PREP state
  logic signed [ERR_W-1:0] err;
  logic signed [NUM_W-1:0] sum_raw, lim_pos, lim_neg, sum_clamped;
  logic signed [EXT_W-1:0] acc_ext;

  assign err     = ERR_W'(target_q) - ERR_W'(meas_q);
  assign sum_raw = NUM_W'(integ_q) + NUM_W'(err);
  assign lim_pos = $signed({{(NUM_W-LIMIT_W){1'b0}}, limit_q});
  assign lim_neg = -lim_pos;
  // Anti-windup clamp on the new sum
  always_comb begin
    priority if (sum_raw > lim_pos) sum_clamped = lim_pos;
    else if (sum_raw < lim_neg)     sum_clamped = lim_neg;
    else                            sum_clamped = sum_raw;
  end

  assign acc_ext = {{(EXT_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_req.start = start_q;
    unique case (state_q)
      ST_DIV_I: begin
        div_req.num = NUM_W'(integ_q);
        div_req.den = i_div_q;
      end
      ST_DIV_D: begin
        div_req.num = diff_q;
        div_req.den = d_div_q;
      end
      default: begin
        div_req.num = NUM_W'(prev_err_q);
        div_req.den = p_div_q;
      end
    endcase
  end

  pdgc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    meas_d      = meas_q;
    integ_d     = integ_q;
    prev_err_d  = prev_err_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    drive_d     = drive_q;
    sat_d       = sat_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          meas_d  = measured_speed_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // state is advanced here; later steps read the updated registers
        diff_d     = NUM_W'(err) - NUM_W'(prev_err_q);
        integ_d    = sum_clamped[INTEG_W-1:0];
        prev_err_d = err;
        acc_d      = '0;
        start_d    = 1'b1;
        state_d    = ST_DIV_P;
      end
      ST_DIV_P: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + ACC_W'(div_rsp.quot);
          start_d = 1'b1;
          state_d = ST_DIV_I;
        end
      end
      ST_DIV_I: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + ACC_W'(div_rsp.quot);
          start_d = 1'b1;
          state_d = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (div_rsp.done) begin
          acc_d   = acc_q + ACC_W'(div_rsp.quot);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          priority if (acc_ext > SAT_HI) begin
            drive_d = SAT_HI[DATA_WIDTH-1:0];
            sat_d   = 1'b1;
          end else if (acc_ext < SAT_LO) begin
            drive_d = SAT_LO[DATA_WIDTH-1:0];
            sat_d   = 1'b1;
          end else begin
            drive_d = acc_ext[DATA_WIDTH-1:0];
            sat_d   = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_err_q  <= '0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      prev_err_q  <= prev_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    meas_q  <= meas_d;
    diff_q  <= diff_d;
    acc_q   <= acc_d;
    drive_q <= drive_d;
    sat_q   <= sat_d;
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign drive_value_o      = drive_q;
  assign output_saturated_o = sat_q;

endmodule

// ===== rtl/pdgc_div.sv =====
// Iterative signed divider, truncating toward zero, two quotient bits per cycle.
module pdgc_div
  import pdgc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    neg_q, neg_d;
  logic [DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIV_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]        den_q, den_d;
  logic [NUM_W-1:0]        quo_q, quo_d;
  logic signed [NUM_W-1:0] quot_q, quot_d;

  logic [DIV_W-1:0] step_rem;
  logic [NUM_W-1:0] step_quo;
  logic [DIV_W:0]   trial;

  // Restoring step, DIV_BITS_PER_CYCLE bits deep
  always_comb begin
    step_rem = rem_q;
    step_quo = quo_q;
    trial    = '0;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      trial    = {step_rem, step_quo[NUM_W-1]};
      step_quo = {step_quo[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        step_rem    = DIV_W'(trial - {1'b0, den_q});
        step_quo[0] = 1'b1;
      end else begin
        step_rem = trial[DIV_W-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.num[NUM_W-1];
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = (req_i.den == '0) ? DIV_W'(1) : req_i.den;  // zero acts as one
      quo_d  = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
    end else if (busy_q) begin
      rem_d = step_rem;
      quo_d = step_quo;
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quot_d = neg_q ? -$signed(step_quo) : $signed(step_quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== tb/sv/pid_divisor_gain_controller_test.sv =====
// Self-checking testbench for the PID controller with divisor gains and clamped integral.
`timescale 1ns / 100ps

module pid_divisor_gain_controller_test;
  import pdgc_pkg::*;

  localparam int unsigned DW = DEFAULT_DATA_WIDTH;
  // Margin of idle cycles when draining, beyond the block's own per-sample work
  localparam int DRAIN_CYCLES = 48;
  // Longest quiet stretch of a correct run is a long send gap plus the
  // block's own cycles plus a long receive stall; take it several times over
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 20;
  localparam int SAMPLES_PER_PHASE = 85;

  typedef struct {
    logic signed [DW-1:0] drive;
    logic                 sat;
  } drive_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SPEED_W-1:0] measured_speed_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DW-1:0]      drive_value_o;
  logic                      output_saturated_o;

  // Shadow copy of the register file and of the controller state
  logic signed [SPEED_W-1:0] set_point;
  logic [DIV_W-1:0]          p_div;
  logic [DIV_W-1:0]          i_div;
  logic [DIV_W-1:0]          d_div;
  logic [LIMIT_W-1:0]        integ_limit;
  logic signed [INTEG_W-1:0] integ_sum;
  logic signed [ERR_W-1:0]   prior_err;

  logic signed [SPEED_W-1:0] speed_samples[$];  // samples still to be sent
  drive_t                    drive_expect[$];   // predicted drive values in order
  int                        mismatches = 0;
  int                        send_gap = 0;
  int                        stall_left = 0;
  int                        quiet_cycles = 0;
  bit                        no_idle = 1'b0;    // phase without gaps or stalls

  pid_divisor_gain_controller #(.DATA_WIDTH(DW)) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .measured_speed_i,
    .out_valid_o,
    .out_ready_i,
    .drive_value_o,
    .output_saturated_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // Idle length: mostly none or short, now and then long enough to span a
  // whole divide sequence
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // A zero divisor register passes the term through undivided
  function automatic longint divisor_of(input logic [DIV_W-1:0] r);
    return (r == '0) ? 64'sd1 : longint'(r);
  endfunction

  // One control step: new error, clamped integral, three truncating
  // quotients, then saturation to DW bits
  function automatic void predict_drive(input logic signed [SPEED_W-1:0] meas);
    longint err;
    longint acc;
    longint lim;
    longint u;
    longint hi;
    longint lo;
    drive_t res;
    err = longint'(set_point) - longint'(meas);
    acc = longint'(integ_sum) + err;
    lim = longint'(integ_limit);
    hi  = (64'sd1 <<< (DW - 1)) - 1;
    lo  = -hi - 1;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    u = err / divisor_of(p_div) + acc / divisor_of(i_div)
        + (err - longint'(prior_err)) / divisor_of(d_div);
    integ_sum = acc[INTEG_W-1:0];
    prior_err = err[ERR_W-1:0];
    res.sat = 1'b0;
    if (u > hi) begin
      u = hi;
      res.sat = 1'b1;
    end else if (u < lo) begin
      u = lo;
      res.sat = 1'b1;
    end
    res.drive = u[DW-1:0];
    drive_expect.push_back(res);
  endfunction

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge that closes the access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      REG_TARGET_SPEED:   set_point   = data[SPEED_W-1:0];
      REG_P_DIVISOR:      p_div       = data[DIV_W-1:0];
      REG_I_DIVISOR:      i_div       = data[DIV_W-1:0];
      REG_D_DIVISOR:      d_div       = data[DIV_W-1:0];
      REG_INTEGRAL_LIMIT: integ_limit = data[LIMIT_W-1:0];
      default: ;  // unmapped address, ignored
    endcase
  endtask

  // Writes to addresses past the register map must leave everything alone
  task automatic write_unmapped();
    for (int k = REG_INTEGRAL_LIMIT + 1; k < 2 ** 3; k++) begin
      write_reg(k[2:0], $urandom());
    end
  endtask

  // Wait until every sample is sent and every result is back, then let the
  // block settle before the register file is touched
  task automatic drain();
    while (speed_samples.size() != 0 || in_valid_i || drive_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DIV_W-1:0] rand_divisor();
    int r;
    r = $urandom_range(0, 9);
    unique case (r)
      0:       return '0;
      1:       return 15'd1;
      2:       return 15'h7FFF;
      3, 4, 5: return 15'($urandom_range(2, 64));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  // New random register settings; extremes come up often. Upper bits of the
  // write data carry noise that the registers must drop.
  task automatic randomize_regs();
    logic [APB_DW-1:0] noise;
    int r;
    noise = $urandom();
    r = $urandom_range(0, 9);
    unique case (r)
      0:       write_reg(REG_TARGET_SPEED, {noise[31:16], 16'h8000});
      1:       write_reg(REG_TARGET_SPEED, {noise[31:16], 16'h7FFF});
      2, 3, 4: write_reg(REG_TARGET_SPEED, {noise[31:16], 16'($urandom_range(0, 2000) - 1000)});
      default: write_reg(REG_TARGET_SPEED, {noise[31:16], 16'($urandom())});
    endcase
    noise = $urandom();
    write_reg(REG_P_DIVISOR, {noise[31:15], rand_divisor()});
    noise = $urandom();
    write_reg(REG_I_DIVISOR, {noise[31:15], rand_divisor()});
    noise = $urandom();
    write_reg(REG_D_DIVISOR, {noise[31:15], rand_divisor()});
    noise = $urandom();
    r = $urandom_range(0, 7);
    unique case (r)
      0:       write_reg(REG_INTEGRAL_LIMIT, {noise[31:15], 15'd0});
      1:       write_reg(REG_INTEGRAL_LIMIT, {noise[31:15], 15'h7FFF});
      2, 3, 4: write_reg(REG_INTEGRAL_LIMIT, {noise[31:15], 15'($urandom_range(1, 300))});
      default: write_reg(REG_INTEGRAL_LIMIT, {noise[31:15], 15'($urandom())});
    endcase
    if ($urandom_range(0, 3) == 0) write_unmapped();
  endtask

  // Nearly half the samples lie near the setpoint so the integral builds up and unwinds
  // without pinning at its bound; the rest spans the full range.
  function automatic logic signed [SPEED_W-1:0] rand_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = int'(set_point) + int'($urandom_range(0, 400)) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SPEED_W-1:0];
    end
    if (r < 55) begin
      unique case ($urandom_range(0, 2))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        default: return set_point;
      endcase
    end
    return 16'($urandom());
  endfunction

  // Sample driver: presents queued samples, holds each until its transaction
  // completes, and predicts the result at the accepting edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_drive(measured_speed_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (speed_samples.size() != 0) begin
          in_valid_i       <= 1'b1;
          measured_speed_i <= speed_samples.pop_front();
          send_gap         <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, each result checked against the
  // oldest prediction.
  always @(posedge clk_i) begin
    drive_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (drive_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result drive=%0d sat=%0b",
                                    drive_value_o, output_saturated_o));
        end else begin
          want = drive_expect.pop_front();
          if (drive_value_o !== want.drive) begin
            report_mismatch($sformatf("drive_value got %0d want %0d",
                                      drive_value_o, want.drive));
          end
          if (output_saturated_o !== want.sat) begin
            report_mismatch($sformatf("output_saturated got %0b want %0b",
                                      output_saturated_o, want.sat));
          end
        end
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: any transaction or register access counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int at_reset[$] = '{32767, -32768, 0, -1, 1, 32767, -32768, 21845, -21846};
    int at_max_target[$] = '{-32768, -32768, 32767, -32768, 0, 32767};
    int at_min_target[$] = '{32767, 32767, -32768, 0, -1};

    // Reset values of the register file and state
    set_point   = '0;
    p_div       = 15'd1;
    i_div       = 15'd1;
    d_div       = 15'd1;
    integ_limit = '0;
    integ_sum   = '0;
    prior_err   = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero limit holds the integral at 0; full-scale swings
    // exercise the wide error and difference
    foreach (at_reset[k]) speed_samples.push_back(SPEED_W'(at_reset[k]));
    drain();

    // Highest setpoint with zero divisors (act as 1) and the widest bound
    write_reg(REG_TARGET_SPEED, 32'h0000_7FFF);
    write_reg(REG_P_DIVISOR, 32'h0000_0000);
    write_reg(REG_I_DIVISOR, 32'h0000_0000);
    write_reg(REG_D_DIVISOR, 32'h0000_0000);
    write_reg(REG_INTEGRAL_LIMIT, 32'h0000_7FFF);
    write_unmapped();
    foreach (at_max_target[k]) speed_samples.push_back(SPEED_W'(at_max_target[k]));
    drain();

    // Lowest setpoint with the largest divisors
    write_reg(REG_TARGET_SPEED, 32'hFFFF_8000);
    write_reg(REG_P_DIVISOR, 32'h0000_7FFF);
    write_reg(REG_I_DIVISOR, 32'h0000_7FFF);
    write_reg(REG_D_DIVISOR, 32'h0000_7FFF);
    foreach (at_min_target[k]) speed_samples.push_back(SPEED_W'(at_min_target[k]));
    drain();

    // Random phases, each with its own register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      randomize_regs();
      no_idle = ($urandom_range(0, 4) == 0);
      for (int n = 0; n < SAMPLES_PER_PHASE; n++) speed_samples.push_back(rand_sample());
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pdgc_pkg.sv
rtl/pdgc_div.sv
rtl/pid_divisor_gain_controller.sv
tb/sv/pid_divisor_gain_controller_test.sv
